[rtl/pit_pkg.sv]
// ----------------------------------------------------------------------------
// pit_pkg
// Shared types and codes for the polygon index triangulator: result status
// codes, the polygon job descriptor and the bank release message.
// ----------------------------------------------------------------------------
package pit_pkg;

	localparam int MAX_VERTICES_DEF = 32;

	// wide enough for a vertex count at any supported MAX_VERTICES (up to 127)
	localparam int CNT_MAX_W = 7;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TOO_FEW  = 2'd1;
	localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

	typedef struct packed {
		logic                 bank;
		logic [CNT_MAX_W-1:0] count;
		logic [1:0]           status;
	} job_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

endpackage

[rtl/pit_front.sv]
// ----------------------------------------------------------------------------
// pit_front
// Accepts vertex indices into one of two index banks, counts and classifies
// the polygon, and hands a job descriptor to the job queue on the last item.
// ----------------------------------------------------------------------------
module pit_front #(
	parameter int MAX_VERTICES = pit_pkg::MAX_VERTICES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [15:0]                         vertex_index,
	input  logic                                last,
	input  logic                                vertex_valid,
	output logic                                vertex_ready,
	output logic                                job_push,
	output pit_pkg::job_t                       job,
	input  pit_pkg::rel_t                       rel,
	input  logic                                rd_en,
	input  logic [$clog2(MAX_VERTICES):0]       rd_addr,
	output logic [15:0]                         rd_data
);

	localparam int AW  = $clog2(MAX_VERTICES);
	localparam int CW  = $clog2(MAX_VERTICES + 1);
	localparam int JCW = pit_pkg::CNT_MAX_W;

	logic [15:0]   mem [2**(AW+1)];
	logic [15:0]   rd_data_q;
	logic          bank_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [1:0]    busy_q;

	logic          accept;
	logic          cnt_full;
	logic [CW-1:0] n_fin;
	logic          ovf_fin;
	logic [1:0]    busy_set;
	logic [1:0]    busy_clr;

	assign vertex_ready = !busy_q[bank_q];
	assign accept       = vertex_valid && vertex_ready;
	assign cnt_full     = (cnt_q == CW'(MAX_VERTICES));
	assign n_fin        = cnt_full ? cnt_q : cnt_q + CW'(1);
	assign ovf_fin      = ovf_q || cnt_full;
	assign busy_set     = (accept && last) ? (2'b01 << bank_q) : 2'b00;
	assign busy_clr     = rel.valid ? (2'b01 << rel.bank) : 2'b00;

	assign job_push = accept && last;
	always_comb begin
		job.bank  = bank_q;
		job.count = JCW'(n_fin);
		if (ovf_fin) begin
			job.status = pit_pkg::STATUS_TOO_MANY;
		end else if (n_fin < CW'(3)) begin
			job.status = pit_pkg::STATUS_TOO_FEW;
		end else begin
			job.status = pit_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			busy_q <= '0;
		end else begin
			busy_q <= (busy_q & ~busy_clr) | busy_set;
			if (accept) begin
				if (last) begin
					cnt_q  <= '0;
					ovf_q  <= 1'b0;
					bank_q <= !bank_q;
				end else if (cnt_full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !cnt_full) begin
			mem[{bank_q, cnt_q[AW-1:0]}] <= vertex_index;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/pit_job_fifo.sv]
// ----------------------------------------------------------------------------
// pit_job_fifo
// Two-entry queue of polygon jobs between the front and the back end.
// ----------------------------------------------------------------------------
module pit_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pit_pkg::job_t push_job,
	input  logic          pop,
	output logic          avail,
	output pit_pkg::job_t head
);

	pit_pkg::job_t entry_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	assign avail = (cnt_q != 2'd0);
	assign head  = entry_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= push_job;
		end
	end

endmodule

[rtl/pit_back.sv]
// ----------------------------------------------------------------------------
// pit_back
// Walks the index stream of one polygon, keeps the re-queued head entries in
// an append store, and emits one triangle or one error result at a time.
// ----------------------------------------------------------------------------
module pit_back #(
	parameter int MAX_VERTICES = pit_pkg::MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_avail,
	input  pit_pkg::job_t                 job_head,
	output logic                          job_pop,
	output pit_pkg::rel_t                 rel,
	output logic                          rd_en,
	output logic [$clog2(MAX_VERTICES):0] rd_addr,
	input  logic [15:0]                   rd_data,
	output logic [15:0]                   corner_a,
	output logic [15:0]                   corner_b,
	output logic [15:0]                   corner_c,
	output logic                          final_triangle,
	output logic [1:0]                    status,
	output logic                          triangle_valid,
	input  logic                          triangle_ready
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int JW = $clog2(2 * MAX_VERTICES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FILL = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [15:0]   app [2**AW];
	logic [15:0]   app_rd_q;

	logic [1:0]    state_q;
	logic          bank_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] m_q;
	logic [JW-1:0] j_q;
	logic [1:0]    need_q;
	logic          pend_q;
	logic [1:0]    f_q;
	logic          sel_q;
	logic [15:0]   a_q;
	logic [15:0]   b_q;
	logic [15:0]   c_q;
	logic          out_valid_q;
	logic [15:0]   out_a_q;
	logic [15:0]   out_b_q;
	logic [15:0]   out_c_q;
	logic          out_fin_q;
	logic [1:0]    out_st_q;

	logic          ofree;
	logic          last_tri;
	logic          in_idx;
	logic          issue;
	logic          job_err;
	logic          emit_go;
	logic          err_go;
	logic [JW-1:0] app_diff;
	logic [15:0]   cap_data;

	assign ofree    = !out_valid_q || triangle_ready;
	assign last_tri = (m_q == n_q - CW'(3));
	assign in_idx   = (j_q < JW'(n_q));
	assign emit_go  = (state_q == ST_EMIT) && ofree;
	assign issue    = ((state_q == ST_FILL) && (need_q != 2'd0)) || (emit_go && !last_tri);
	assign job_err  = (job_head.status != pit_pkg::STATUS_OK);
	assign job_pop  = (state_q == ST_IDLE) && job_avail && (!job_err || ofree);
	assign err_go   = job_pop && job_err;

	assign rel.valid = err_go || (emit_go && last_tri);
	assign rel.bank  = job_pop ? job_head.bank : bank_q;

	assign rd_en    = issue && in_idx;
	assign rd_addr  = {bank_q, j_q[AW-1:0]};
	assign app_diff = j_q - JW'(n_q);
	assign cap_data = sel_q ? rd_data : app_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bank_q      <= 1'b0;
			n_q         <= '0;
			m_q         <= '0;
			j_q         <= '0;
			need_q      <= 2'd0;
			pend_q      <= 1'b0;
			f_q         <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (ofree) begin
				out_valid_q <= err_go || emit_go;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_pop && !job_err) begin
						bank_q  <= job_head.bank;
						n_q     <= CW'(job_head.count);
						m_q     <= '0;
						j_q     <= '0;
						need_q  <= 2'd3;
						pend_q  <= 1'b0;
						f_q     <= 2'd0;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (pend_q) begin
						f_q <= f_q + 2'd1;
					end
					if (need_q != 2'd0) begin
						need_q <= need_q - 2'd1;
						j_q    <= j_q + JW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && (f_q == 2'd2)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (ofree) begin
						m_q <= m_q + CW'(1);
						if (last_tri) begin
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + JW'(1);
							need_q  <= 2'd1;
							pend_q  <= 1'b1;
							f_q     <= 2'd1;
							state_q <= ST_FILL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			sel_q <= in_idx;
		end
		if ((state_q == ST_FILL) && pend_q) begin
			case (f_q)
				2'd0:    a_q <= cap_data;
				2'd1:    b_q <= cap_data;
				default: c_q <= cap_data;
			endcase
		end
		if (emit_go && !last_tri) begin
			a_q <= c_q;
		end
		if (err_go) begin
			out_a_q   <= '0;
			out_b_q   <= '0;
			out_c_q   <= '0;
			out_fin_q <= 1'b1;
			out_st_q  <= job_head.status;
		end else if (emit_go) begin
			out_a_q   <= a_q;
			out_b_q   <= b_q;
			out_c_q   <= c_q;
			out_fin_q <= last_tri;
			out_st_q  <= pit_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			app[m_q[AW-1:0]] <= a_q;
		end
		if (issue && !in_idx) begin
			app_rd_q <= app[app_diff[AW-1:0]];
		end
	end

	assign corner_a       = out_a_q;
	assign corner_b       = out_b_q;
	assign corner_c       = out_c_q;
	assign final_triangle = out_fin_q;
	assign status         = out_st_q;
	assign triangle_valid = out_valid_q;

endmodule

[rtl/polygon_index_triangulator_unit.sv]
// ----------------------------------------------------------------------------
// polygon_index_triangulator_unit
// Loads one vertex index per cycle, while its target bank is not busy, into
// a ping-pong index store; after the last index it emits n - 2 triangles.
// The front loads the next polygon while the back end emits the previous one.
// Reset clears all control state; the index stores are not cleared.
// ----------------------------------------------------------------------------
module polygon_index_triangulator_unit #(
	parameter int MAX_VERTICES = pit_pkg::MAX_VERTICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] vertex_index,
	input  logic        last,
	input  logic        vertex_valid,
	output logic        vertex_ready,
	output logic [15:0] corner_a,
	output logic [15:0] corner_b,
	output logic [15:0] corner_c,
	output logic        final_triangle,
	output logic [1:0]  status,
	output logic        triangle_valid,
	input  logic        triangle_ready
);

	localparam int AW = $clog2(MAX_VERTICES);

	logic          job_push;
	pit_pkg::job_t job_in;
	logic          job_pop;
	logic          job_avail;
	pit_pkg::job_t job_head;
	pit_pkg::rel_t rel;
	logic          rd_en;
	logic [AW:0]   rd_addr;
	logic [15:0]   rd_data;

	pit_front #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.vertex_index(vertex_index),
		.last        (last),
		.vertex_valid(vertex_valid),
		.vertex_ready(vertex_ready),
		.job_push    (job_push),
		.job         (job_in),
		.rel         (rel),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data)
	);

	pit_job_fifo u_job_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.push_job(job_in),
		.pop     (job_pop),
		.avail   (job_avail),
		.head    (job_head)
	);

	pit_back #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_avail     (job_avail),
		.job_head      (job_head),
		.job_pop       (job_pop),
		.rel           (rel),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.corner_a      (corner_a),
		.corner_b      (corner_b),
		.corner_c      (corner_c),
		.final_triangle(final_triangle),
		.status        (status),
		.triangle_valid(triangle_valid),
		.triangle_ready(triangle_ready)
	);

endmodule
